### sv/rtbf_pkg.sv
// ============================================================================
// rtbf_pkg - shared types and codes of the radio TX/RX byte FIFO
// Opcodes, status codes and the status bundles passed from the TX and RX
// sections to the top level.
// ============================================================================
`default_nettype none

package rtbf_pkg;

    // Frame check bytes appended by hardware when auto-CRC is on
    localparam int CRC_BYTES = 2;

    typedef enum logic [2:0] {
        OP_TX_WRITE   = 3'd0,
        OP_RX_PUSH    = 3'd1,
        OP_RX_PEEK    = 3'd2,
        OP_RX_POP     = 3'd3,
        OP_RX_READ_AT = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADLEN = 3'd3,
        ST_DONE   = 3'd4,
        ST_SHORT  = 3'd5
    } t_status;

    // TX section result for the item being accepted (values after the item)
    typedef struct packed {
        t_status    status;
        logic [7:0] fill;
        logic       complete;
    } t_tx_stat;

    // RX section result for the item being accepted (values after the item)
    typedef struct packed {
        t_status    status;
        logic [6:0] fill;
        logic       rd;      // a ring read was issued and returns valid data
    } t_rx_stat;

endpackage

`default_nettype wire

### sv/rtbf_ram.sv
// ============================================================================
// rtbf_ram - generic single-clock RAM
// One write port and one read port; read data is registered and holds
// while no read is enabled.
// ============================================================================
`default_nettype none

module rtbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/rtbf_tx_frame.sv
// ============================================================================
// rtbf_tx_frame - length-framed transmit FIFO
// Checks the length byte, tracks bytes needed and present, and stores the
// accepted bytes in the TX memory.
// ============================================================================
`default_nettype none

module rtbf_tx_frame #(
    parameter int TX_DEPTH         = 128,
    parameter int MAX_FRAME_LENGTH = 127
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_auto_crc,
    input  wire logic              i_wr,
    input  wire logic [7:0]        i_byte,
    output rtbf_pkg::t_tx_stat     o_stat
);

    localparam int TCW = $clog2(TX_DEPTH + 1);
    localparam int TAW = $clog2(TX_DEPTH);

    logic [TCW-1:0]      r_count,   n_count;
    logic [7:0]          r_needed,  n_needed;
    logic [7:0]          r_present, n_present;
    logic                w_mem_wr;
    logic [6:0]          w_len;
    logic [6:0]          w_min_len;
    rtbf_pkg::t_status   w_status;

    assign w_len     = i_byte[6:0];
    assign w_min_len = i_auto_crc ? 7'(rtbf_pkg::CRC_BYTES) : 7'd1;

    // Frame bookkeeping for one write
    always_comb begin
        n_count   = r_count;
        n_needed  = r_needed;
        n_present = r_present;
        w_mem_wr  = 1'b0;
        w_status  = rtbf_pkg::ST_OK;
        if (i_wr) begin
            priority if (r_count == TCW'(TX_DEPTH)) begin
                w_status = rtbf_pkg::ST_FULL;
            end else if (r_count == '0) begin
                if (w_len > 7'(MAX_FRAME_LENGTH) || w_len < w_min_len) begin
                    w_status = rtbf_pkg::ST_BADLEN;
                end else begin
                    n_needed  = i_auto_crc ? ({1'b0, w_len} - 8'd1) : ({1'b0, w_len} + 8'd1);
                    n_present = 8'd0;
                    n_count   = TCW'(1);
                    w_mem_wr  = 1'b1;
                end
            end else if (r_present == r_needed) begin
                w_status = rtbf_pkg::ST_DONE;
            end else begin
                n_count   = r_count + TCW'(1);
                n_present = r_present + 8'd1;
                w_mem_wr  = 1'b1;
            end
        end
    end

    // Hold frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_needed  <= 8'd0;
            r_present <= 8'd0;
        end else begin
            r_count   <= n_count;
            r_needed  <= n_needed;
            r_present <= n_present;
        end
    end

    // Byte store; the write slot is the current count (zero for the length byte)
    rtbf_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr),
        .i_wr_addr (r_count[TAW-1:0]),
        .i_wr_data (i_byte),
        .i_rd_en   (1'b0),
        .i_rd_addr ('0),
        .o_rd_data ()
    );

    assign o_stat.status   = w_status;
    assign o_stat.fill     = 8'(n_count);
    assign o_stat.complete = (n_count != '0) && (n_present == n_needed);

endmodule

`default_nettype wire

### sv/rtbf_rx_ring.sv
// ============================================================================
// rtbf_rx_ring - receive ring buffer
// Head and tail pointers over the RX memory with one slot kept free; push,
// peek, pop and a length-checked read at a wrapped offset.
// ============================================================================
`default_nettype none

module rtbf_rx_ring #(
    parameter int RX_DEPTH = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire rtbf_pkg::t_opcode i_op,
    input  wire logic [7:0]        i_byte,
    input  wire logic [6:0]        i_start,
    input  wire logic [6:0]        i_offset,
    input  wire logic [6:0]        i_req,
    output rtbf_pkg::t_rx_stat     o_stat,
    output logic      [7:0]        o_rd_data
);

    localparam int RAW = $clog2(RX_DEPTH);

    logic [RAW-1:0]      r_head, n_head;
    logic [RAW-1:0]      r_tail, n_tail;
    logic [RAW-1:0]      w_head_inc;
    logic [RAW-1:0]      w_tail_inc;
    logic [RAW-1:0]      w_held;
    logic                w_empty;
    logic                w_full;
    logic [7:0]          w_sum;
    logic [RAW-1:0]      w_mod [256];
    logic                w_wr;
    logic                w_rd;
    logic [RAW-1:0]      w_rd_addr;
    rtbf_pkg::t_status   w_status;

    // Bytes held between head and tail
    function automatic logic [RAW-1:0] held_of(input logic [RAW-1:0] tail,
                                               input logic [RAW-1:0] head);
        logic [RAW:0] diff;
        diff = {1'b0, tail} - {1'b0, head};
        if (diff[RAW]) begin
            diff = diff + (RAW+1)'(RX_DEPTH);
        end
        return diff[RAW-1:0];
    endfunction

    // Wrap table for start + offset
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod[g] = RAW'(g % RX_DEPTH);
    end

    assign w_head_inc = (r_head == RAW'(RX_DEPTH - 1)) ? '0 : r_head + RAW'(1);
    assign w_tail_inc = (r_tail == RAW'(RX_DEPTH - 1)) ? '0 : r_tail + RAW'(1);
    assign w_held     = held_of(r_tail, r_head);
    assign w_empty    = (r_head == r_tail);
    assign w_full     = (w_tail_inc == r_head);
    assign w_sum      = {1'b0, i_start} + {1'b0, i_offset};

    // Ring operation for one item
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        w_wr      = 1'b0;
        w_rd      = 1'b0;
        w_rd_addr = r_head;
        w_status  = rtbf_pkg::ST_OK;
        if (i_valid) begin
            unique case (i_op)
                rtbf_pkg::OP_RX_PUSH: begin
                    if (w_full) begin
                        w_status = rtbf_pkg::ST_FULL;
                    end else begin
                        w_wr   = 1'b1;
                        n_tail = w_tail_inc;
                    end
                end
                rtbf_pkg::OP_RX_PEEK,
                rtbf_pkg::OP_RX_POP: begin
                    if (w_empty) begin
                        w_status = rtbf_pkg::ST_EMPTY;
                    end else begin
                        w_rd = 1'b1;
                        if (i_op == rtbf_pkg::OP_RX_POP) begin
                            n_head = w_head_inc;
                        end
                    end
                end
                rtbf_pkg::OP_RX_READ_AT: begin
                    priority if (w_empty) begin
                        w_status = rtbf_pkg::ST_EMPTY;
                    end else if (9'(w_held) < 9'(i_req)) begin
                        w_status = rtbf_pkg::ST_SHORT;
                    end else begin
                        w_rd      = 1'b1;
                        w_rd_addr = w_mod[w_sum];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    rtbf_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr),
        .i_wr_addr (r_tail),
        .i_wr_data (i_byte),
        .i_rd_en   (w_rd),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (o_rd_data)
    );

    assign o_stat.status = w_status;
    assign o_stat.fill   = 7'(held_of(n_tail, n_head));
    assign o_stat.rd     = w_rd;

endmodule

`default_nettype wire

### sv/radio_tx_rx_byte_fifo.sv
// ============================================================================
// radio_tx_rx_byte_fifo - radio TX frame FIFO and RX ring buffer
// Top level: stream ports, auto-CRC register, result stage and output
// register.
// ============================================================================
// The block takes one item per clock and returns exactly one result item for
// each. Its result is held in the result stage, together with the registered
// read of the RX ring memory, and then in the output register.
// Back-pressure on the output holds the result stage, and the input is taken
// again as soon as the result stage can move on, so a sustained rate of one
// item per cycle is reached while the output is ready. The TX and RX stores
// come up uninitialized; no clearing pass runs after reset. The first TX byte
// of a frame is its length; the frame then takes length + 1 bytes, or
// length - 1 with auto-CRC on. The TX FIFO is emptied only by reset.
`default_nettype none

module radio_tx_rx_byte_fifo #(
    parameter int TX_DEPTH         = 128,
    parameter int RX_DEPTH         = 128,
    parameter int MAX_FRAME_LENGTH = 127
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: auto_crc_enable
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // write_byte[7:0], rx_start[14:8],
                                            // byte_offset[21:15], request_length[28:22]
    input  wire logic [2:0]  s_axis_tuser,  // opcode[2:0]
    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata   // read_byte[7:0], status[10:8], tx_fill[18:11],
                                            // tx_frame_complete[19], rx_fill[26:20]
);

    logic                 r_auto_crc;
    logic                 w_accept;
    rtbf_pkg::t_opcode    w_op;
    rtbf_pkg::t_tx_stat   w_tx_stat;
    rtbf_pkg::t_rx_stat   w_rx_stat;
    logic [7:0]           w_rx_rd_data;
    rtbf_pkg::t_status    w_status;
    logic                 w_s1_move;

    logic                 r_s1_valid;
    logic                 r_s1_rd;
    rtbf_pkg::t_status    r_s1_status;
    logic [7:0]           r_s1_tx_fill;
    logic                 r_s1_tx_done;
    logic [6:0]           r_s1_rx_fill;

    logic                 r_out_valid;
    logic [31:0]          r_out_data;

    assign w_op     = rtbf_pkg::t_opcode'(s_axis_tuser);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Hold the auto-CRC register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_crc <= 1'b1;
        end else if (i_cfg_we) begin
            r_auto_crc <= i_cfg_wdata;
        end
    end

    rtbf_tx_frame #(
        .TX_DEPTH         (TX_DEPTH),
        .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
    ) u_tx_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_auto_crc (r_auto_crc),
        .i_wr       (w_accept && (w_op == rtbf_pkg::OP_TX_WRITE)),
        .i_byte     (s_axis_tdata[7:0]),
        .o_stat     (w_tx_stat)
    );

    rtbf_rx_ring #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_op      (w_op),
        .i_byte    (s_axis_tdata[7:0]),
        .i_start   (s_axis_tdata[14:8]),
        .i_offset  (s_axis_tdata[21:15]),
        .i_req     (s_axis_tdata[28:22]),
        .o_stat    (w_rx_stat),
        .o_rd_data (w_rx_rd_data)
    );

    // Pick the status of the section that handled the item
    assign w_status = (w_op == rtbf_pkg::OP_TX_WRITE) ? w_tx_stat.status : w_rx_stat.status;

    // Advance the result stage when the output register is free or drains
    assign w_s1_move     = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_move;

    // Result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Result stage payload, waits for the ring read data
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_rd      <= w_rx_stat.rd;
            r_s1_status  <= w_status;
            r_s1_tx_fill <= w_tx_stat.fill;
            r_s1_tx_done <= w_tx_stat.complete;
            r_s1_rx_fill <= w_rx_stat.fill;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_data <= {5'd0,
                           r_s1_rx_fill,
                           r_s1_tx_done,
                           r_s1_tx_fill,
                           r_s1_status,
                           (r_s1_rd ? w_rx_rd_data : 8'd0)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
